>>> rtl/mpc_pkg.sv
// Shared constants, types and codes for the moisture pump controller.
package mpc_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int TICK_BITS   = 16;

  localparam int CFG_DATA_BITS = (TICK_BITS > SAMPLE_BITS) ? TICK_BITS : SAMPLE_BITS;
  localparam int CFG_IDX_BITS  = 2;

  localparam int FILT_KEEP = 29;
  localparam int FILT_DIV  = 30;

  localparam int SUM_BITS    = SAMPLE_BITS + 5;
  localparam int RECIP_SHIFT = SUM_BITS + 4;
  localparam int PROD_BITS   = SUM_BITS + RECIP_SHIFT;
  localparam longint unsigned RECIP = (64'd1 << RECIP_SHIFT) / FILT_DIV;

  localparam logic [SAMPLE_BITS-1:0] DRY_THRESHOLD_RST = SAMPLE_BITS'(2048);
  localparam logic [TICK_BITS-1:0]   PUMP_TICKS_RST    = TICK_BITS'(5);
  localparam logic [TICK_BITS-1:0]   WAIT_TICKS_RST    = TICK_BITS'(600);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_DRY_THRESHOLD = 2'd0,
    CFG_PUMP_TICKS    = 2'd1,
    CFG_WAIT_TICKS    = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    REQ_DISPLAY = 1'b0,
    REQ_TICK    = 1'b1
  } req_kind_t;

  typedef enum logic [1:0] {
    PH_INIT  = 2'd0,
    PH_CHECK = 2'd1,
    PH_PUMP  = 2'd2,
    PH_WAIT  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] dry_threshold;
    logic [TICK_BITS-1:0]   pump_ticks;
    logic [TICK_BITS-1:0]   wait_ticks;
  } cfg_t;

  typedef struct packed {
    logic                   req_type;
    logic [SAMPLE_BITS-1:0] sample;
  } word_t;

endpackage

>>> rtl/mpc_req_if.sv
// Request channel: item kind and raw sample with valid/ready.
interface mpc_req_if;
  import mpc_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   req_type;
  logic [SAMPLE_BITS-1:0] sample;
  modport source (output valid, req_type, sample, input ready);
  modport sink   (input valid, req_type, sample, output ready);
endinterface

>>> rtl/mpc_rsp_if.sv
// Result channel: pump drive, smoothed level and phase with valid/ready.
interface mpc_rsp_if;
  import mpc_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   pump_on;
  logic [SAMPLE_BITS-1:0] level;
  logic [1:0]             phase;
  modport source (output valid, pump_on, level, phase, input ready);
  modport sink   (input valid, pump_on, level, phase, output ready);
endinterface

>>> rtl/mpc_avg.sv
// Moving-average step: (old*29 + sample)/30 by reciprocal multiply and one correction.
module mpc_avg (
  input  logic [mpc_pkg::SAMPLE_BITS-1:0] old_level,
  input  logic [mpc_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                            primed,
  output logic [mpc_pkg::SAMPLE_BITS-1:0] new_level
);
  import mpc_pkg::*;

  logic [SUM_BITS-1:0]  sum;
  logic [PROD_BITS-1:0] prod;
  logic [SUM_BITS-1:0]  quot;
  logic [SUM_BITS-1:0]  rem;
  logic [SUM_BITS-1:0]  quot_fix;

  always_comb begin
    sum      = SUM_BITS'(old_level) * SUM_BITS'(FILT_KEEP) + SUM_BITS'(sample);
    prod     = PROD_BITS'(sum) * PROD_BITS'(RECIP);
    quot     = SUM_BITS'(prod >> RECIP_SHIFT);
    rem      = sum - quot * SUM_BITS'(FILT_DIV);
    quot_fix = (rem >= SUM_BITS'(FILT_DIV)) ? quot + SUM_BITS'(1) : quot;
    new_level = primed ? quot_fix[SAMPLE_BITS-1:0] : sample;
  end

endmodule

>>> rtl/mpc_core.sv
// Controller state, phase logic and result register.
module mpc_core (
  input  logic            clk,
  input  logic            rst,
  input  mpc_pkg::cfg_t   cfg,
  input  logic            word_valid,
  input  mpc_pkg::word_t  word,
  output logic            take,
  mpc_rsp_if.source       rsp
);
  import mpc_pkg::*;

  logic [SAMPLE_BITS-1:0] level_q, level_next;
  logic                   primed_q, primed_next;
  phase_t                 phase_q, phase_next;
  logic [TICK_BITS-1:0]   ticks_q, ticks_next;
  logic                   pump_q, pump_next;

  logic [SAMPLE_BITS-1:0] avg_level;
  logic                   use_sample;
  logic [TICK_BITS-1:0]   ticks_mid;

  mpc_avg u_avg (
    .old_level (level_q),
    .sample    (word.sample),
    .primed    (primed_q),
    .new_level (avg_level)
  );

  assign take = word_valid && (!rsp.valid || rsp.ready);

  always_comb begin
    use_sample = (word.req_type == REQ_DISPLAY) || (phase_q == PH_CHECK);
    level_next  = use_sample ? avg_level : level_q;
    primed_next = primed_q || use_sample;
    phase_next  = phase_q;
    pump_next   = pump_q;
    ticks_mid   = ticks_q;
    ticks_next  = ticks_q;
    if (word.req_type == REQ_TICK) begin
      case (phase_q)
        PH_INIT: begin
          pump_next  = 1'b0;
          phase_next = PH_CHECK;
        end
        PH_CHECK: begin
          if (avg_level > cfg.dry_threshold) begin
            phase_next = PH_PUMP;
            ticks_mid  = cfg.pump_ticks;
          end else begin
            phase_next = PH_WAIT;
            ticks_mid  = cfg.wait_ticks;
          end
        end
        PH_PUMP: begin
          pump_next = 1'b1;
          if (ticks_q == '0) begin
            pump_next  = 1'b0;
            phase_next = PH_WAIT;
            ticks_mid  = cfg.wait_ticks;
          end
        end
        default: begin
          if (ticks_q == '0) begin
            phase_next = PH_CHECK;
          end
        end
      endcase
      ticks_next = (ticks_mid != '0) ? ticks_mid - TICK_BITS'(1) : ticks_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_q   <= '0;
      primed_q  <= 1'b0;
      phase_q   <= PH_INIT;
      ticks_q   <= '0;
      pump_q    <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (take) begin
        level_q     <= level_next;
        primed_q    <= primed_next;
        phase_q     <= phase_next;
        ticks_q     <= ticks_next;
        pump_q      <= pump_next;
        rsp.valid   <= 1'b1;
        rsp.pump_on <= pump_next;
        rsp.level   <= level_next;
        rsp.phase   <= phase_next;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  a_pump_only_in_pump: assert property (@(posedge clk) disable iff (rst)
    pump_q |-> (phase_q == PH_PUMP))
    else $error("pump driven outside pump phase");

  a_check_timer_idle: assert property (@(posedge clk) disable iff (rst)
    (phase_q == PH_CHECK) |-> (ticks_q == '0))
    else $error("timer running in check phase");

  a_unprimed_level_zero: assert property (@(posedge clk) disable iff (rst)
    !primed_q |-> (level_q == '0))
    else $error("level nonzero before first sample");

  a_init_not_reentered: assert property (@(posedge clk) disable iff (rst)
    (phase_q != PH_INIT) |=> (phase_q != PH_INIT))
    else $error("init phase reentered");

  a_state_holds_idle: assert property (@(posedge clk) disable iff (rst)
    !take |=> ($stable(phase_q) && $stable(ticks_q) && $stable(level_q)))
    else $error("state changed without a word");

endmodule

>>> rtl/moisture_pump_controller_top.sv
// Top level of the moisture pump controller: config registers, input stage and core.
//
// Each request word (display refresh or control tick) yields one result word carrying
// pump drive, smoothed level and phase. A word is accepted whenever the staging
// register is empty or the core takes its word. The word waits in the input staging
// register while the averaging filter and phase logic compute from it, and it lands
// in the result register when the core takes it. Sustained rate is one word per
// cycle while the result side stays ready. Both registers hold under backpressure,
// and the input stays ready while a finished result waits if the staging slot is free.
// Configuration writes take effect at the next clock edge.
module moisture_pump_controller_top (
  input  logic                              clk,
  input  logic                              rst,
  mpc_req_if.sink                           req,
  mpc_rsp_if.source                         rsp,
  input  logic                              cfg_we,
  input  logic [mpc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [mpc_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);
  import mpc_pkg::*;

  cfg_t  cfg_q;
  logic  stg_valid;
  word_t stg_word;
  logic  take;

  assign req.ready = !stg_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.dry_threshold <= DRY_THRESHOLD_RST;
      cfg_q.pump_ticks    <= PUMP_TICKS_RST;
      cfg_q.wait_ticks    <= WAIT_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DRY_THRESHOLD: cfg_q.dry_threshold <= cfg_wdata[SAMPLE_BITS-1:0];
        CFG_PUMP_TICKS:    cfg_q.pump_ticks    <= cfg_wdata[TICK_BITS-1:0];
        CFG_WAIT_TICKS:    cfg_q.wait_ticks    <= cfg_wdata[TICK_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (req.ready) begin
      stg_valid <= req.valid;
      if (req.valid) begin
        stg_word.req_type <= req.req_type;
        stg_word.sample   <= req.sample;
      end
    end
  end

  mpc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_q),
    .word_valid (stg_valid),
    .word       (stg_word),
    .take       (take),
    .rsp        (rsp)
  );

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the moisture pump controller: predicted status per word.
module testbench;
  import mpc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_WORDS_PER_SET = 230;
  localparam int HOLD_CYCLES = 300;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_IDX = 2'd3;

  typedef struct packed {
    logic                   pump_on;
    logic [SAMPLE_BITS-1:0] level;
    phase_t                 phase;
  } status_t;

  class pump_status_board;
    logic [SAMPLE_BITS-1:0] threshold;
    logic [TICK_BITS-1:0]   pump_len;
    logic [TICK_BITS-1:0]   wait_len;
    logic [SAMPLE_BITS-1:0] level;
    bit                     primed;
    phase_t                 ph;
    logic [TICK_BITS-1:0]   ticks_left;
    bit                     pump;
    status_t                status_q[$];
    int                     errors;

    function new();
      threshold  = DRY_THRESHOLD_RST;
      pump_len   = PUMP_TICKS_RST;
      wait_len   = WAIT_TICKS_RST;
      level      = '0;
      primed     = 1'b0;
      ph         = PH_INIT;
      ticks_left = '0;
      pump       = 1'b0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
      case (idx)
        CFG_DRY_THRESHOLD: threshold = val[SAMPLE_BITS-1:0];
        CFG_PUMP_TICKS:    pump_len  = val[TICK_BITS-1:0];
        CFG_WAIT_TICKS:    wait_len  = val[TICK_BITS-1:0];
        default: ;
      endcase
    endfunction

    function void smooth(logic [SAMPLE_BITS-1:0] s);
      int unsigned acc;
      if (!primed) begin
        level  = s;
        primed = 1'b1;
      end else begin
        acc   = (int'(level) * FILT_KEEP + int'(s)) / FILT_DIV;
        level = acc[SAMPLE_BITS-1:0];
      end
    endfunction

    function void take_word(req_kind_t kind, logic [SAMPLE_BITS-1:0] s);
      status_t st;
      if (kind == REQ_DISPLAY) begin
        smooth(s);
      end else begin
        case (ph)
          PH_INIT: begin
            pump = 1'b0;
            ph   = PH_CHECK;
          end
          PH_CHECK: begin
            smooth(s);
            if (level > threshold) begin
              ph         = PH_PUMP;
              ticks_left = pump_len;
            end else begin
              ph         = PH_WAIT;
              ticks_left = wait_len;
            end
          end
          PH_PUMP: begin
            pump = 1'b1;
            if (ticks_left == 0) begin
              pump       = 1'b0;
              ph         = PH_WAIT;
              ticks_left = wait_len;
            end
          end
          default: begin
            if (ticks_left == 0) ph = PH_CHECK;
          end
        endcase
        if (ticks_left != 0) ticks_left = ticks_left - 1'b1;
      end
      st.pump_on = pump;
      st.level   = level;
      st.phase   = ph;
      status_q.push_back(st);
    endfunction

    function void report(string field, int want, int got);
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void check_status(logic pump_on, logic [SAMPLE_BITS-1:0] lvl, logic [1:0] phs);
      status_t want;
      if (status_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected status word: pump %0d level %0d phase %0d",
                 $time, pump_on, lvl, phs);
        return;
      end
      want = status_q.pop_front();
      if (pump_on !== want.pump_on) report("pump_on", want.pump_on, pump_on);
      if (lvl !== want.level) report("level", want.level, lvl);
      if (phs !== want.phase) report("phase", want.phase, phs);
    endfunction

    function int pending();
      return status_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  mpc_req_if req_ch();
  mpc_rsp_if rsp_ch();

  moisture_pump_controller_top u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  pump_status_board board;
  int send_idle_pct = 6;
  int recv_idle_pct = 47;
  bit hold_request = 1'b0;
  int cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int hold_left;
    hold_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      board.check_status(rsp_ch.pump_on, rsp_ch.level, rsp_ch.phase);
  end

  task automatic send_word(req_kind_t kind, logic [SAMPLE_BITS-1:0] s);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 8) gap++;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.sample   <= s;
    do @(posedge clk); while (!req_ch.ready);
    board.take_word(kind, s);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    board.write_reg(idx, val);
  endtask

  task automatic apply_settings(logic [15:0] thr, logic [15:0] pl, logic [15:0] wl);
    write_reg(CFG_DRY_THRESHOLD, thr);
    write_reg(CFG_PUMP_TICKS, pl);
    write_reg(CFG_WAIT_TICKS, wl);
    write_reg(CFG_SPARE_IDX, 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [15:0] thr_set[8]  = '{16'd2048, 16'd0, 16'd4095, 16'd1000,
                                 16'd0, 16'd3000, 16'd0, 16'hFFFF};
    logic [15:0] pump_set[8] = '{16'd3, 16'd0, 16'd2, 16'd65535,
                                 16'd0, 16'd1, 16'd0, 16'd0};
    logic [15:0] wait_set[8] = '{16'd5, 16'd0, 16'd1, 16'd2,
                                 16'd0, 16'd65535, 16'd0, 16'd3};
    logic [15:0] thr, pl, wl;
    int target, smp, mode;
    req_kind_t kind;

    board = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_DISPLAY;
    req_ch.sample = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(REQ_TICK, 12'hFFF);
    send_word(REQ_TICK, 12'hFFF);
    repeat (6) send_word(REQ_TICK, 12'h000);
    send_word(REQ_DISPLAY, 12'h000);
    send_word(REQ_DISPLAY, 12'hFFF);
    send_word(REQ_DISPLAY, 12'hAAA);
    send_word(REQ_DISPLAY, 12'h555);
    drain();
    apply_settings(16'hFFFF, 16'd0, 16'd0);
    for (int i = 0; i < 8; i++) send_word(REQ_TICK, i[0] ? 12'hFFF : 12'h000);
    drain();
    apply_settings(16'd0, 16'd1, 16'd1);
    repeat (5) send_word(REQ_TICK, 12'h800);
    drain();

    target = 2048;
    for (int p = 0; p < 8; p++) begin
      mode = p * 3 / 8;
      send_idle_pct = (mode == 0) ? 6 : (mode == 1) ? 47 : 0;
      recv_idle_pct = (mode == 0) ? 47 : (mode == 1) ? 6 : 0;
      thr = thr_set[p];
      pl  = pump_set[p];
      wl  = wait_set[p];
      if (p == 4 || p == 6) begin
        thr = 16'($urandom_range(65535));
        pl  = 16'($urandom_range(8));
        wl  = 16'($urandom_range(12));
      end
      apply_settings(thr, pl, wl);
      if (p == 1) hold_request = 1'b1;
      for (int n = 0; n < RAND_WORDS_PER_SET; n++) begin
        if (n % 32 == 0)
          target = $urandom_range(1) ? $urandom_range(4095, 3000) : $urandom_range(1100, 0);
        if ($urandom_range(9) == 0) begin
          smp = $urandom_range(4095);
        end else begin
          smp = target + $urandom_range(400) - 200;
          if (smp < 0) smp = 0;
          if (smp > 4095) smp = 4095;
        end
        kind = ($urandom_range(99) < 60) ? REQ_TICK : REQ_DISPLAY;
        send_word(kind, smp[SAMPLE_BITS-1:0]);
      end
      drain();
    end

    repeat (6) @(posedge clk);
    if (board.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
